@@ hw/rtl/ddlr_pkg.sv @@
// Shared types and constants for the dash-dot line rasterizer.
// Used by ddlr_core and the top level; depends on nothing.

package ddlr_pkg;

  localparam int COORD_W = 10;
  localparam int ERR_W   = 12;
  localparam int PAT_W   = 5;
  localparam int POS_W   = 3;

  localparam int PATTERN_LENGTH_DEF = 5;
  localparam logic [PAT_W-1:0] DASH_RESET = 5'd13;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] goal_y;
    logic [COORD_W-1:0]        delta_x;
    logic [COORD_W-1:0]        delta_y;
    logic                      step_x_neg;
    logic                      step_y_neg;
    logic signed [ERR_W-1:0]   error_term;
    logic [POS_W-1:0]          pattern_pos;
    logic                      busy;
  } line_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      draw;
    logic                      last;
  } point_t;

endpackage

@@ hw/rtl/dash_dot_line_rasterizer.sv @@
// Top level of the dash-dot line rasterizer: handshakes, line state and result register.
// Depends on ddlr_pkg and ddlr_core.
//
// Usage:
//   The input stream carries requests. in_tuser selects the kind: a start request
//   loads two endpoints from in_tdata and gives no point; an advance request gives
//   the next point of the running line on the output stream. An advance request
//   while no line is running is taken and dropped. A start request during a line
//   drops that line and begins the new one.
//   Each point carries its coordinates in out_tdata, the dash pattern bit in
//   out_tuser and, on the end point, out_tlast; the line then goes idle.
//   A point from an accepted advance request shows on out_tvalid in the cycle after it.
//   Throughput is one request per cycle while in_tready stays high; the state update
//   is a single pass of logic between the line registers and the result register.
//   When the receiver stalls, the point waits in the result register and
//   in_tready stays high only while that register is free or being emptied.
//   Reset (rst_n low, synchronous) makes the line idle, empties the result
//   register and sets the dash pattern to 5'b01101. The user must write the pattern through
//   the always-ready cfg channel only while the block is idle; the block does not enforce it.

module dash_dot_line_rasterizer #(
  parameter int PATTERN_LENGTH = ddlr_pkg::PATTERN_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // start_x[9:0], start_y[19:10], end_x[29:20], end_y[39:30]
  input  logic [0:0]  in_tuser,   // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // point_x[9:0], point_y[19:10], zero[23:20]
  output logic [0:0]  out_tuser,  // draw[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ddlr_pkg::PAT_W-1:0] cfg_data
);

  localparam int CW = ddlr_pkg::COORD_W;

  ddlr_pkg::line_state_t state_r;
  ddlr_pkg::line_state_t state_nxt;
  ddlr_pkg::point_t      point_r;
  ddlr_pkg::point_t      point_nxt;
  logic                  point_valid;
  logic                  out_valid_r;
  logic [ddlr_pkg::PAT_W-1:0] pattern_r;
  logic                  in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  ddlr_core #(
    .PATTERN_LENGTH(PATTERN_LENGTH)
  ) u_core (
    .state       (state_r),
    .opcode      (in_tuser[0]),
    .start_x     (in_tdata[CW-1:0]),
    .start_y     (in_tdata[2*CW-1:CW]),
    .end_x       (in_tdata[3*CW-1:2*CW]),
    .end_y       (in_tdata[4*CW-1:3*CW]),
    .dash_pattern(pattern_r),
    .state_nxt   (state_nxt),
    .point       (point_nxt),
    .point_valid (point_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
      pattern_r   <= ddlr_pkg::DASH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_r <= cfg_data;
      end
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept && point_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && point_valid) begin
      point_r <= point_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, point_r.point_y, point_r.point_x};
  assign out_tuser  = point_r.draw;
  assign out_tlast  = point_r.last;

endmodule

@@ hw/rtl/ddlr_core.sv @@
// Next-state and point logic of the line walk for one request.
// Depends on ddlr_pkg for the state and point types.

module ddlr_core #(
  parameter int PATTERN_LENGTH = ddlr_pkg::PATTERN_LENGTH_DEF
) (
  input  ddlr_pkg::line_state_t                    state,
  input  logic                                     opcode,
  input  logic signed [ddlr_pkg::COORD_W-1:0]      start_x,
  input  logic signed [ddlr_pkg::COORD_W-1:0]      start_y,
  input  logic signed [ddlr_pkg::COORD_W-1:0]      end_x,
  input  logic signed [ddlr_pkg::COORD_W-1:0]      end_y,
  input  logic [ddlr_pkg::PAT_W-1:0]               dash_pattern,
  output ddlr_pkg::line_state_t                    state_nxt,
  output ddlr_pkg::point_t                         point,
  output logic                                     point_valid
);

  localparam int CW = ddlr_pkg::COORD_W;
  localparam int EW = ddlr_pkg::ERR_W;

  logic signed [CW:0]   dx_s;
  logic signed [CW:0]   dy_s;
  logic [CW-1:0]        dx_abs;
  logic [CW-1:0]        dy_abs;
  logic                 last;
  logic                 draw;
  logic [ddlr_pkg::POS_W:0] pos_inc;
  logic signed [EW+1:0] e2;
  logic signed [EW+1:0] dx_w;
  logic signed [EW+1:0] dy_w;
  logic signed [EW+1:0] err_w;

  always_comb begin
    dx_s   = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    dy_s   = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    dx_abs = dx_s[CW] ? CW'(-dx_s) : dx_s[CW-1:0];
    dy_abs = dy_s[CW] ? CW'(-dy_s) : dy_s[CW-1:0];

    last = (state.cur_x == state.goal_x) && (state.cur_y == state.goal_y);
    if (state.pattern_pos < ddlr_pkg::POS_W'(ddlr_pkg::PAT_W)) begin
      draw = dash_pattern[state.pattern_pos];
    end else begin
      draw = 1'b0;
    end
    pos_inc = {1'b0, state.pattern_pos} + 1'b1;

    // Bresenham decision on twice the error term, all at 14 bits so nothing wraps.
    e2    = {state.error_term[EW-1], state.error_term, 1'b0};
    dx_w  = {4'b0000, state.delta_x};
    dy_w  = {4'b0000, state.delta_y};
    err_w = {{2{state.error_term[EW-1]}}, state.error_term};

    state_nxt   = state;
    point       = '0;
    point_valid = 1'b0;

    if (opcode == ddlr_pkg::OP_START) begin
      state_nxt.cur_x       = start_x;
      state_nxt.cur_y       = start_y;
      state_nxt.goal_x      = end_x;
      state_nxt.goal_y      = end_y;
      state_nxt.delta_x     = dx_abs;
      state_nxt.delta_y     = dy_abs;
      state_nxt.step_x_neg  = !(start_x < end_x);
      state_nxt.step_y_neg  = !(start_y < end_y);
      state_nxt.error_term  = {2'b00, dx_abs} - {2'b00, dy_abs};
      state_nxt.pattern_pos = '0;
      state_nxt.busy        = 1'b1;
    end else if (state.busy) begin
      point_valid   = 1'b1;
      point.point_x = state.cur_x;
      point.point_y = state.cur_y;
      point.draw    = draw;
      point.last    = last;

      if (pos_inc >= (ddlr_pkg::POS_W+1)'(PATTERN_LENGTH)) begin
        state_nxt.pattern_pos = '0;
      end else begin
        state_nxt.pattern_pos = pos_inc[ddlr_pkg::POS_W-1:0];
      end

      if (last) begin
        state_nxt.busy = 1'b0;
      end else begin
        if (e2 > -dy_w) begin
          err_w = err_w - dy_w;
          state_nxt.cur_x = state.cur_x + (state.step_x_neg ? {CW{1'b1}} : CW'(1));
        end
        if (e2 < dx_w) begin
          err_w = err_w + dx_w;
          state_nxt.cur_y = state.cur_y + (state.step_y_neg ? {CW{1'b1}} : CW'(1));
        end
        state_nxt.error_term = err_w[EW-1:0];
      end
    end
  end

endmodule

@@ hw/rtl/ddlr_checker.sv @@
// Port-level checks for the dash-dot line rasterizer, bound to the top level.
// Sees only the top-level ports; depends on nothing else.

module ddlr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);

  // A held point must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("point changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result register not empty after reset");

  // A new point appears only after an accepted advance request.
  a_point_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser[0]))
    else $error("point without an advance request");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // A start request never produces a point.
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] && (!out_tvalid || out_tready)
      |=> !out_tvalid)
    else $error("start request produced a point");

endmodule

bind dash_dot_line_rasterizer ddlr_checker u_ddlr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);
